// File: rtl/core/tpba_pkg.sv
package tpba_pkg;

	localparam int CH_W    = 8;
	localparam int CFG_W   = 16;
	localparam int OUT_W   = 48;
	localparam int Q_DEPTH = 2;

	localparam int VALUE_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int COUNT_BITS_DEF = 16;

	localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;
	localparam logic [CH_W-1:0] CH_NINE    = 8'h39;
	localparam logic [CH_W-1:0] CH_NEWLINE = 8'h0A;
	localparam logic [CFG_W-1:0] BIN_SIZE_RST = 16'd1;

	typedef enum logic [3:0] {
		PH_FIRST  = 4'b0001,
		PH_SEP    = 4'b0010,
		PH_SECOND = 4'b0100,
		PH_EOL    = 4'b1000
	} phase_t;

	typedef enum logic [2:0] {
		DV_IDLE = 3'b001,
		DV_RUN  = 3'b010,
		DV_DONE = 3'b100
	} div_state_t;

	function automatic logic is_digit(input logic [CH_W-1:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

endpackage

// File: rtl/core/text_pair_bin_averager_top.sv
// Input: one text byte per cycle while the bin queue has room.
// Output: a result appears after the newline that closes a bin, once the shift-subtract divider,
// which takes one quotient bit a cycle, has run; the divider works on one bin at a time,
// and a two-entry bin queue lets parsing run ahead.
// Reset (arst_n low, asynchronous): parser to first number, sums and counts zero, bin length 1.
module text_pair_bin_averager_top #(
	parameter int VALUE_BITS = tpba_pkg::VALUE_BITS_DEF,
	parameter int FRAC_BITS  = tpba_pkg::FRAC_BITS_DEF,
	parameter int COUNT_BITS = tpba_pkg::COUNT_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [tpba_pkg::CH_W-1:0]      s_tdata,   // ch
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [2*tpba_pkg::OUT_W-1:0]   m_tdata,   // mean_x, mean_y
	input  logic                           cfg_we,
	input  logic [tpba_pkg::CFG_W-1:0]     cfg_wdata  // lines per bin
);
	localparam int SW = VALUE_BITS + COUNT_BITS;
	localparam int QW = 2 * SW + COUNT_BITS;

	logic                  q_full, q_empty, q_push, q_pop;
	logic [SW-1:0]         f_sx, f_sy;
	logic [COUNT_BITS-1:0] f_bin;
	logic [QW-1:0]         q_rdata;

	tpba_front #(.VALUE_BITS(VALUE_BITS), .COUNT_BITS(COUNT_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.q_full(q_full), .q_push(q_push),
		.q_sum_x(f_sx), .q_sum_y(f_sy), .q_bin(f_bin)
	);

	tpba_queue #(.WIDTH(QW)) u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(q_push), .wdata({f_bin, f_sy, f_sx}),
		.pop(q_pop), .rdata(q_rdata),
		.full(q_full), .empty(q_empty)
	);

	tpba_div #(.VALUE_BITS(VALUE_BITS), .FRAC_BITS(FRAC_BITS),
		.COUNT_BITS(COUNT_BITS)) u_div (
		.clk(clk), .arst_n(arst_n),
		.q_empty(q_empty), .q_pop(q_pop),
		.q_sum_x(q_rdata[SW-1:0]), .q_sum_y(q_rdata[2*SW-1:SW]),
		.q_bin(q_rdata[QW-1:2*SW]),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

endmodule

// File: rtl/core/tpba_front.sv
module tpba_front #(
	parameter int VALUE_BITS = tpba_pkg::VALUE_BITS_DEF,
	parameter int COUNT_BITS = tpba_pkg::COUNT_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [tpba_pkg::CH_W-1:0]           s_tdata,
	input  logic                                cfg_we,
	input  logic [tpba_pkg::CFG_W-1:0]          cfg_wdata,
	input  logic                                q_full,
	output logic                                q_push,
	output logic [VALUE_BITS+COUNT_BITS-1:0]    q_sum_x,
	output logic [VALUE_BITS+COUNT_BITS-1:0]    q_sum_y,
	output logic [COUNT_BITS-1:0]               q_bin
);
	localparam int SW = VALUE_BITS + COUNT_BITS;
	localparam int EW = tpba_pkg::CFG_W + COUNT_BITS;

	logic [tpba_pkg::CFG_W-1:0] bin_len_q;
	tpba_pkg::phase_t           phase_q;
	logic [VALUE_BITS-1:0]      vx_q, vy_q, vx_dig, vy_dig;
	logic [SW-1:0]              sx_q, sy_q, sx_new, sy_new;
	logic [COUNT_BITS-1:0]      lc_q, lc_new, bin_eff;
	logic [EW-1:0]              bs_ext, cnt_max;
	logic                       acc, digit, nl, complete, bin_done;

	function automatic logic [VALUE_BITS-1:0] push_digit(
		input logic [VALUE_BITS-1:0] v, input logic [tpba_pkg::CH_W-1:0] c);
		logic [VALUE_BITS+3:0] n;
		n = ({4'd0, v} << 3) + ({4'd0, v} << 1) + (VALUE_BITS+4)'(c[3:0]);
		return (n[VALUE_BITS+3:VALUE_BITS] != 4'd0) ? '1 : n[VALUE_BITS-1:0];
	endfunction

	assign s_tready = !q_full;
	assign acc      = s_tvalid && s_tready;
	assign digit    = tpba_pkg::is_digit(s_tdata);
	assign nl       = (s_tdata == tpba_pkg::CH_NEWLINE);
	assign vx_dig   = push_digit(vx_q, s_tdata);
	assign vy_dig   = push_digit(vy_q, s_tdata);

	// zero acts as one, oversize clamps to the counter range
	assign bs_ext  = EW'(bin_len_q);
	assign cnt_max = {{tpba_pkg::CFG_W{1'b0}}, {COUNT_BITS{1'b1}}};
	always_comb begin
		if (bin_len_q == '0) begin
			bin_eff = COUNT_BITS'(1);
		end else if (bs_ext > cnt_max) begin
			bin_eff = '1;
		end else begin
			bin_eff = bs_ext[COUNT_BITS-1:0];
		end
	end

	always_comb begin
		complete = 1'b0;
		case (phase_q)
			tpba_pkg::PH_SECOND: complete = !digit && nl;
			tpba_pkg::PH_EOL:    complete = nl;
			default:             complete = 1'b0;
		endcase
	end

	assign sx_new   = sx_q + SW'(vx_q);
	assign sy_new   = sy_q + SW'(vy_q);
	assign lc_new   = lc_q + COUNT_BITS'(1);
	assign bin_done = (lc_new == bin_eff);

	assign q_push  = acc && complete && bin_done;
	assign q_sum_x = sx_new;
	assign q_sum_y = sy_new;
	assign q_bin   = bin_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_len_q  <= tpba_pkg::BIN_SIZE_RST;
			phase_q    <= tpba_pkg::PH_FIRST;
			vx_q       <= '0;
			vy_q       <= '0;
			sx_q       <= '0;
			sy_q       <= '0;
			lc_q       <= '0;
		end else begin
			if (cfg_we) begin
				bin_len_q <= cfg_wdata;
			end
			if (acc) begin
				if (complete) begin
					phase_q <= tpba_pkg::PH_FIRST;
					vx_q    <= '0;
					vy_q    <= '0;
					if (bin_done) begin
						sx_q <= '0;
						sy_q <= '0;
						lc_q <= '0;
					end else begin
						sx_q <= sx_new;
						sy_q <= sy_new;
						lc_q <= lc_new;
					end
				end else begin
					case (phase_q)
						tpba_pkg::PH_FIRST: begin
							if (digit) vx_q <= vx_dig;
							else phase_q <= tpba_pkg::PH_SEP;
						end
						tpba_pkg::PH_SEP: begin
							if (digit) begin
								vy_q    <= vy_dig;
								phase_q <= tpba_pkg::PH_SECOND;
							end
						end
						tpba_pkg::PH_SECOND: begin
							if (digit) vy_q <= vy_dig;
							else phase_q <= tpba_pkg::PH_EOL;
						end
						default: phase_q <= phase_q;
					endcase
				end
			end
		end
	end

endmodule

// File: rtl/core/tpba_queue.sv
module tpba_queue #(
	parameter int WIDTH = 1
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);
	localparam int PW = $clog2(tpba_pkg::Q_DEPTH);
	localparam int CW = $clog2(tpba_pkg::Q_DEPTH + 1);

	logic [WIDTH-1:0] mem_q [tpba_pkg::Q_DEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [CW-1:0]    cnt_q;

	assign full  = (cnt_q == CW'(tpba_pkg::Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= (wp_q == PW'(tpba_pkg::Q_DEPTH-1)) ? '0 : wp_q + PW'(1);
			if (pop)  rp_q <= (rp_q == PW'(tpba_pkg::Q_DEPTH-1)) ? '0 : rp_q + PW'(1);
			cnt_q <= cnt_q + CW'(push) - CW'(pop);
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n) !(push && full))
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n) !(pop && empty))
		else $error("pop from empty queue");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(tpba_pkg::Q_DEPTH))
		else $error("queue count out of range");
`endif

endmodule

// File: rtl/core/tpba_div.sv
module tpba_div #(
	parameter int VALUE_BITS = tpba_pkg::VALUE_BITS_DEF,
	parameter int FRAC_BITS  = tpba_pkg::FRAC_BITS_DEF,
	parameter int COUNT_BITS = tpba_pkg::COUNT_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 q_empty,
	output logic                                 q_pop,
	input  logic [VALUE_BITS+COUNT_BITS-1:0]     q_sum_x,
	input  logic [VALUE_BITS+COUNT_BITS-1:0]     q_sum_y,
	input  logic [COUNT_BITS-1:0]                q_bin,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [2*tpba_pkg::OUT_W-1:0]         m_tdata
);
	localparam int SW = VALUE_BITS + COUNT_BITS;
	localparam int DW = SW + FRAC_BITS;
	localparam int CW = $clog2(DW);
	localparam int OW = tpba_pkg::OUT_W;

	tpba_pkg::div_state_t st_q;
	logic [DW-1:0]         dx_q, dy_q;
	logic [COUNT_BITS-1:0] rx_q, ry_q, n_q;
	logic [CW-1:0]         cnt_q;
	logic [COUNT_BITS:0]   r2x, r2y, subx, suby;
	logic                  gex, gey, load_out;
	logic [DW+OW-1:0]      extx, exty;
	logic [OW-1:0]         mx_q, my_q;
	logic                  ov_q;

	// restoring divide, one quotient bit per cycle, quotient shifts into the dividend reg
	assign r2x  = {rx_q, dx_q[DW-1]};
	assign r2y  = {ry_q, dy_q[DW-1]};
	assign subx = r2x - {1'b0, n_q};
	assign suby = r2y - {1'b0, n_q};
	assign gex  = (r2x >= {1'b0, n_q});
	assign gey  = (r2y >= {1'b0, n_q});

	assign extx = {{OW{1'b0}}, dx_q};
	assign exty = {{OW{1'b0}}, dy_q};

	assign q_pop    = (st_q == tpba_pkg::DV_IDLE) && !q_empty;
	assign load_out = (st_q == tpba_pkg::DV_DONE) && (!ov_q || m_tready);
	assign m_tvalid = ov_q;
	assign m_tdata  = {my_q, mx_q};

	always_ff @(posedge clk) begin
		if (q_pop) begin
			dx_q <= DW'(q_sum_x) << FRAC_BITS;
			dy_q <= DW'(q_sum_y) << FRAC_BITS;
			n_q  <= q_bin;
			rx_q <= '0;
			ry_q <= '0;
		end else if (st_q == tpba_pkg::DV_RUN) begin
			dx_q <= {dx_q[DW-2:0], gex};
			dy_q <= {dy_q[DW-2:0], gey};
			rx_q <= gex ? subx[COUNT_BITS-1:0] : r2x[COUNT_BITS-1:0];
			ry_q <= gey ? suby[COUNT_BITS-1:0] : r2y[COUNT_BITS-1:0];
		end
		if (load_out) begin
			mx_q <= extx[OW-1:0];
			my_q <= exty[OW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= tpba_pkg::DV_IDLE;
			cnt_q <= '0;
			ov_q  <= 1'b0;
		end else begin
			case (st_q)
				tpba_pkg::DV_IDLE: begin
					if (q_pop) begin
						st_q  <= tpba_pkg::DV_RUN;
						cnt_q <= '0;
					end
				end
				tpba_pkg::DV_RUN: begin
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(DW-1)) st_q <= tpba_pkg::DV_DONE;
				end
				tpba_pkg::DV_DONE: begin
					if (load_out) st_q <= tpba_pkg::DV_IDLE;
				end
				default: st_q <= tpba_pkg::DV_IDLE;
			endcase
			if (load_out) ov_q <= 1'b1;
			else if (m_tready) ov_q <= 1'b0;
		end
	end

`ifndef SYNTH
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == tpba_pkg::DV_RUN) |-> (n_q != '0))
		else $error("divide by zero bin");
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == tpba_pkg::DV_RUN) |-> (rx_q < n_q && ry_q < n_q))
		else $error("remainder not below divisor");
	a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == tpba_pkg::DV_DONE && ov_q && !m_tready) |=> (st_q == tpba_pkg::DV_DONE))
		else $error("result dropped while output stalled");
`endif

endmodule
